@@ src/cbf_pkg.sv @@
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared types, codes and hash helpers for the counting Bloom filter.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int          HASH_W      = 64;
    localparam logic [63:0] FNV_BASIS   = 64'hCBF2_9CE4_8422_2325;
    localparam int          SEED_STEP   = 31;
    localparam int          DIGIT_BITS  = 4;
    localparam int          DIGIT_STEPS = HASH_W / DIGIT_BITS;
    localparam int          DIGIT_CNT_W = $clog2(DIGIT_STEPS);

    localparam logic CFG_NUM_HASHES   = 1'b0;
    localparam logic CFG_NUM_COUNTERS = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_CHECK  = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_MAX    = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_t;

    typedef struct packed {
        logic init_busy;
    } bk_stat_t;

    // FNV prime is 2^40 + 0x1B3; 0x1B3 = 256+128+32+16+2+1
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    function automatic logic [63:0] lane_seed(input int lane);
        return FNV_BASIS + 64'(SEED_STEP * lane);
    endfunction

endpackage

@@ src/cbf_queue.sv @@
// ----------------------------------------------------------------------------
// cbf_queue
// Two-entry job queue between the hashing front end and the table back end.
// ----------------------------------------------------------------------------
module cbf_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop,
    output logic [W-1:0] pop_data
);
    logic [W-1:0] data_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = data_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/cbf_front.sv @@
// ----------------------------------------------------------------------------
// cbf_front
// Accepts key bytes, runs the seeded FNV-1a lanes, queues a job at key end.
// ----------------------------------------------------------------------------
module cbf_front #(
    parameter int MAX_HASHES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   req_type,
    input  logic [7:0]                   key_byte,
    input  logic                         byte_valid,
    input  logic                         key_last,
    input  cbf_pkg::bk_stat_t            bk_stat,
    output logic                         push_valid,
    input  logic                         push_ready,
    output logic [2:0]                   push_req,
    output logic [MAX_HASHES-1:0][63:0]  push_hash
);
    import cbf_pkg::*;

    logic [MAX_HASHES-1:0][63:0] lane_reg, lane_next;
    logic                        accept;

    assign in_ready   = !bk_stat.init_busy && (!key_last || push_ready);
    assign accept     = in_valid && in_ready;
    assign push_valid = in_valid && key_last && !bk_stat.init_busy;
    assign push_req   = req_type;

    always_comb
    begin
        for (int i = 0; i < MAX_HASHES; i++)
        begin
            push_hash[i] = byte_valid ? fnv_step(lane_reg[i], key_byte) : lane_reg[i];
            lane_next[i] = lane_reg[i];
            if (accept)
            begin
                lane_next[i] = key_last ? lane_seed(i) : push_hash[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_HASHES; i++)
            begin
                lane_reg[i] <= lane_seed(i);
            end
        end
        else
        begin
            lane_reg <= lane_next;
        end
    end

endmodule

@@ src/cbf_back.sv @@
// ----------------------------------------------------------------------------
// cbf_back
// Reduces lane hashes to counter indexes and runs requests on the table.
// ----------------------------------------------------------------------------
module cbf_back #(
    parameter int TABLE_DEPTH   = 4096,
    parameter int MAX_HASHES    = 16,
    parameter int COUNTER_WIDTH = 32,
    parameter int IDX_W         = $clog2(TABLE_DEPTH),
    parameter int T_W           = IDX_W + 1,
    parameter int K_W           = $clog2(MAX_HASHES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [K_W-1:0]               eff_k,
    input  logic [T_W-1:0]               eff_m,
    input  logic                         job_valid,
    input  logic [2:0]                   job_req,
    input  logic [MAX_HASHES-1:0][63:0]  job_hash,
    output logic                         job_pop,
    output cbf_pkg::bk_stat_t            bk_stat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         status,
    output logic [31:0]                  min_count,
    output logic [63:0]                  elements_count
);
    import cbf_pkg::*;

    localparam int LANE_W = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MOD    = 9'b000000010,
        S_RD     = 9'b000000100,
        S_EVAL   = 9'b000001000,
        S_UPD_RD = 9'b000010000,
        S_UPD_WR = 9'b000100000,
        S_CLR    = 9'b001000000,
        S_DONE   = 9'b010000000,
        S_HOLD   = 9'b100000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [LANE_W-1:0]         lane_reg, lane_next, lane_inc;
    logic [IDX_W-1:0]          rem_reg, rem_next;
    logic [63:0]               sh_reg, sh_next;
    logic [DIGIT_CNT_W-1:0]    dig_reg, dig_next;
    logic [IDX_W-1:0]          idx_reg [MAX_HASHES];
    logic                      idx_we;
    logic                      present_reg, present_next;
    logic [COUNTER_WIDTH-1:0]  minc_reg, minc_next;
    logic [IDX_W-1:0]          clr_addr_reg, clr_addr_next;
    logic                      init_reg, init_next;
    logic [2:0]                req_reg, req_next;
    logic [63:0]               elem_reg, elem_next;
    logic                      pend_status_reg, pend_status_next;
    logic [COUNTER_WIDTH-1:0]  pend_min_reg, pend_min_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      res_status_reg;
    logic [COUNTER_WIDTH-1:0]  res_min_reg;
    logic [63:0]               res_elem_reg;
    logic                      res_load;
    logic                      lane_last;

    logic [COUNTER_WIDTH-1:0]  mem [TABLE_DEPTH];
    logic [COUNTER_WIDTH-1:0]  mem_q;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [COUNTER_WIDTH-1:0]  mem_wdata;
    logic [IDX_W-1:0]          mem_raddr;

    logic [T_W-1:0]            trial;
    logic [IDX_W-1:0]          rem_w;
    logic [63:0]               sh_w;
    logic                      pres_w;

    assign lane_inc          = lane_reg + 1'b1;
    assign lane_last         = ((K_W'(lane_reg) + K_W'(1)) == eff_k);
    assign mem_raddr         = idx_reg[lane_reg];
    assign bk_stat.init_busy = init_reg;
    assign out_valid         = out_valid_reg;
    assign status            = res_status_reg;
    assign min_count         = 32'(res_min_reg);
    assign elements_count    = res_elem_reg;

    // Four restoring-remainder steps per cycle, hash fed MSB first
    always_comb
    begin
        rem_w = rem_reg;
        sh_w  = sh_reg;
        for (int j = 0; j < DIGIT_BITS; j++)
        begin
            trial = {rem_w, sh_w[63]};
            if (trial >= eff_m)
            begin
                trial = trial - eff_m;
            end
            rem_w = trial[IDX_W-1:0];
            sh_w  = sh_w << 1;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        lane_next        = lane_reg;
        rem_next         = rem_reg;
        sh_next          = sh_reg;
        dig_next         = dig_reg;
        idx_we           = 1'b0;
        present_next     = present_reg;
        minc_next        = minc_reg;
        clr_addr_next    = clr_addr_reg;
        init_next        = init_reg;
        req_next         = req_reg;
        elem_next        = elem_reg;
        pend_status_next = pend_status_reg;
        pend_min_next    = pend_min_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        res_load         = 1'b0;
        job_pop          = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg[lane_reg];
        mem_wdata        = mem_q;
        pres_w           = present_reg && (mem_q != '0);

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    req_next         = job_req;
                    pend_status_next = ST_OK;
                    pend_min_next    = '0;
                    lane_next        = '0;
                    rem_next         = '0;
                    dig_next         = '0;
                    sh_next          = job_hash[0];
                    clr_addr_next    = '0;
                    unique case (job_req) inside
                        REQ_CLEAR:
                            state_next = S_CLR;
                        REQ_ADD, REQ_CHECK, REQ_REMOVE, REQ_MAX:
                            state_next = S_MOD;
                        default:
                        begin
                            pend_status_next = ST_FAIL;
                            state_next       = S_DONE;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                rem_next = rem_w;
                sh_next  = sh_w;
                dig_next = dig_reg + 1'b1;
                if (dig_reg == DIGIT_CNT_W'(DIGIT_STEPS - 1))
                begin
                    idx_we = 1'b1;
                    if (lane_last)
                    begin
                        lane_next    = '0;
                        present_next = 1'b1;
                        minc_next    = CNT_MAX;
                        state_next   = (req_reg == REQ_ADD) ? S_UPD_RD : S_RD;
                    end
                    else
                    begin
                        lane_next = lane_inc;
                        rem_next  = '0;
                        dig_next  = '0;
                        sh_next   = job_hash[lane_inc];
                    end
                end
            end
            S_RD:
                state_next = S_EVAL;
            S_EVAL:
            begin
                present_next = pres_w;
                if (mem_q < minc_reg)
                begin
                    minc_next = mem_q;
                end
                if (lane_last)
                begin
                    lane_next        = '0;
                    pend_status_next = pres_w ? ST_OK : ST_FAIL;
                    state_next       = S_DONE;
                    if (req_reg == REQ_REMOVE && pres_w)
                    begin
                        state_next = S_UPD_RD;
                    end
                    if (req_reg == REQ_MAX && pres_w)
                    begin
                        pend_min_next = (mem_q < minc_reg) ? mem_q : minc_reg;
                    end
                end
                else
                begin
                    lane_next  = lane_inc;
                    state_next = S_RD;
                end
            end
            S_UPD_RD:
                state_next = S_UPD_WR;
            S_UPD_WR:
            begin
                if (req_reg == REQ_ADD)
                begin
                    mem_we    = (mem_q != CNT_MAX);
                    mem_wdata = mem_q + 1'b1;
                end
                else
                begin
                    mem_we    = (mem_q != CNT_MAX) && (mem_q != '0);
                    mem_wdata = mem_q - 1'b1;
                end
                if (lane_last)
                begin
                    elem_next        = (req_reg == REQ_ADD) ? elem_reg + 64'd1
                                                            : elem_reg - 64'd1;
                    pend_status_next = ST_OK;
                    state_next       = S_DONE;
                end
                else
                begin
                    lane_next  = lane_inc;
                    state_next = S_UPD_RD;
                end
            end
            S_CLR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        elem_next  = '0;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
                state_next = S_HOLD;
            S_HOLD:
            begin
                // result register frees as soon as the sink takes the last one
                if (!out_valid_reg || out_ready)
                begin
                    res_load       = 1'b1;
                    out_valid_next = 1'b1;
                    job_pop        = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            init_reg      <= 1'b1;
            clr_addr_reg  <= '0;
            lane_reg      <= '0;
            dig_reg       <= '0;
            elem_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_addr_reg  <= clr_addr_next;
            lane_reg      <= lane_next;
            dig_reg       <= dig_next;
            elem_reg      <= elem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg         <= rem_next;
        sh_reg          <= sh_next;
        present_reg     <= present_next;
        minc_reg        <= minc_next;
        req_reg         <= req_next;
        pend_status_reg <= pend_status_next;
        pend_min_reg    <= pend_min_next;
        if (idx_we)
        begin
            idx_reg[lane_reg] <= rem_w;
        end
        if (res_load)
        begin
            res_status_reg <= pend_status_reg;
            res_min_reg    <= pend_min_reg;
            res_elem_reg   <= elem_reg;
        end
    end

    // counter table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (T_W'(rem_reg) < eff_m))
        else $error("remainder not below counter count");

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !job_pop)
        else $error("job retired during clear sweep");

    a_init_only_clear: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> (state_reg == S_CLR))
        else $error("init sweep left before finishing");

    a_remove_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD_WR && mem_we && req_reg == REQ_REMOVE) |-> (mem_q != '0))
        else $error("remove decremented a zero counter");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid_reg)
        else $error("result loaded without valid");

endmodule

@@ src/counting_bloom_filter.sv @@
// ----------------------------------------------------------------------------
// counting_bloom_filter
// Counting Bloom filter over byte keys with K seeded 64-bit FNV-1a hashes.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    req_type, key_byte, byte_valid, key_last
// out      source     out_valid / out_ready  status, min_count, elements_count
// cfg      sink       cfg_we (no wait)       cfg_index, cfg_data
//
// Key bytes are taken one per cycle while in_ready is high; hash lanes update in the same cycle.
// Per key the back end's time is dominated by the 4-bit-per-cycle remainder unit,
// which runs once per hash lane.
// A clear request sweeps the table at one counter per cycle.
// After reset the same sweep runs and in_ready stays low.
// A two-entry job queue lets the front take bytes while the back end works.
// ----------------------------------------------------------------------------
module counting_bloom_filter #(
    parameter int TABLE_DEPTH   = 4096,
    parameter int MAX_HASHES    = 16,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [7:0]  key_byte,
    input  logic        byte_valid,
    input  logic        key_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [31:0] min_count,
    output logic [63:0] elements_count,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    import cbf_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int T_W   = IDX_W + 1;
    localparam int K_W   = $clog2(MAX_HASHES + 1);
    localparam int JOB_W = 3 + MAX_HASHES * 64;

    logic [4:0]                  num_hashes_reg;
    logic [12:0]                 num_counters_reg;
    logic [K_W-1:0]              eff_k;
    logic [T_W-1:0]              eff_m;
    bk_stat_t                    bk_stat;
    logic                        push_valid, push_ready;
    logic [2:0]                  push_req;
    logic [MAX_HASHES-1:0][63:0] push_hash;
    logic                        job_valid, job_pop;
    logic [JOB_W-1:0]            job_data;
    logic [MAX_HASHES-1:0][63:0] job_hash;
    logic [2:0]                  job_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_hashes_reg   <= 5'd7;
            num_counters_reg <= 13'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_HASHES:   num_hashes_reg   <= cfg_data[4:0];
                CFG_NUM_COUNTERS: num_counters_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        if (num_hashes_reg == 5'd0)
            eff_k = K_W'(1);
        else if (32'(num_hashes_reg) > 32'(MAX_HASHES))
            eff_k = K_W'(MAX_HASHES);
        else
            eff_k = K_W'(num_hashes_reg);

        if (num_counters_reg == 13'd0)
            eff_m = T_W'(1);
        else if (32'(num_counters_reg) > 32'(TABLE_DEPTH))
            eff_m = T_W'(TABLE_DEPTH);
        else
            eff_m = T_W'(num_counters_reg);
    end

    assign job_req  = job_data[JOB_W-1 -: 3];
    assign job_hash = job_data[JOB_W-4:0];

    cbf_front #(
        .MAX_HASHES (MAX_HASHES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .key_byte   (key_byte),
        .byte_valid (byte_valid),
        .key_last   (key_last),
        .bk_stat    (bk_stat),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .push_hash  (push_hash)
    );

    cbf_queue #(
        .W (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_req, push_hash}),
        .pop_valid  (job_valid),
        .pop        (job_pop),
        .pop_data   (job_data)
    );

    cbf_back #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_HASHES    (MAX_HASHES),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .eff_k          (eff_k),
        .eff_m          (eff_m),
        .job_valid      (job_valid),
        .job_req        (job_req),
        .job_hash       (job_hash),
        .job_pop        (job_pop),
        .bk_stat        (bk_stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .min_count      (min_count),
        .elements_count (elements_count)
    );

endmodule
